/* rtl/qcf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the quadratic curve flattener.
package qcf_pkg;

  localparam int DENSITY_W     = 12;
  localparam int CFG_DATA_W    = 12;
  localparam int COORD_W       = 32;
  localparam logic FILL_MODE_RESET = 1'b1;
  localparam logic [DENSITY_W-1:0] DENSITY_RESET = 12'd614;

  // Configuration register indexes.
  localparam logic [0:0] CFG_FILL_MODE = 1'b0;
  localparam logic [0:0] CFG_DENSITY   = 1'b1;

  typedef enum logic [1:0] {
    MODE_MOVE = 2'd0,
    MODE_LINE = 2'd1,
    MODE_QUAD = 2'd2,
    MODE_END  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CODE_MOVE = 2'd0,
    CODE_LINE = 2'd1,
    CODE_END  = 2'd2
  } code_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUSH_IN,
    ST_FLUSH,
    ST_END,
    ST_DIFF,
    ST_MUL1,
    ST_MUL2,
    ST_SEARCH,
    ST_SETUP,
    ST_WGT,
    ST_ACC_E,
    ST_ACC_C,
    ST_ACC_S,
    ST_DIVPREP,
    ST_DIV
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH_IN,
    OP_FLUSH,
    OP_END,
    OP_DIFF,
    OP_MUL1,
    OP_MUL2,
    OP_SEARCH,
    OP_SETUP,
    OP_WGT,
    OP_ACC_E,
    OP_ACC_C,
    OP_ACC_S,
    OP_DIVPREP,
    OP_DIVSTEP,
    OP_POINT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  held_valid;
    logic  search_done;
    logic  last_point;
    logic  out_free;
  } stat_t;

  // Width of the Bezier numerator and of the divider's dividend.
  function automatic int num_width(input int max_parts);
    return 35 + 2 * $clog2(max_parts + 1);
  endfunction

endpackage

/* rtl/qcf_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the quadratic curve flattener.
module qcf_ctrl #(
  parameter int MAX_PARTS = 63
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output qcf_pkg::cmd_t  cmd_o,
  input  qcf_pkg::stat_t stat_i
);
  import qcf_pkg::*;

  localparam int NUMW = num_width(MAX_PARTS);
  localparam int CNTW = $clog2(NUMW);

  state_e state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = OP_NONE;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat_i.mode)
          MODE_MOVE, MODE_LINE: state_d = ST_PUSH_IN;
          MODE_QUAD:            state_d = ST_DIFF;
          default:              state_d = ST_FLUSH;
        endcase
      end
      ST_PUSH_IN: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_PUSH_IN;
          state_d  = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!stat_i.held_valid) begin
          state_d = ST_END;
        end else if (stat_i.out_free) begin
          cmd_o.op = OP_FLUSH;
          state_d  = ST_END;
        end
      end
      ST_END: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_END;
          state_d  = ST_IDLE;
        end
      end
      ST_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.op = OP_MUL1;
        state_d  = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.op = OP_MUL2;
        state_d  = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (stat_i.search_done) begin
          state_d = ST_SETUP;
        end else begin
          cmd_o.op = OP_SEARCH;
        end
      end
      ST_SETUP: begin
        cmd_o.op = OP_SETUP;
        state_d  = ST_WGT;
      end
      ST_WGT: begin
        cmd_o.op = OP_WGT;
        state_d  = ST_ACC_E;
      end
      ST_ACC_E: begin
        cmd_o.op = OP_ACC_E;
        state_d  = ST_ACC_C;
      end
      ST_ACC_C: begin
        cmd_o.op = OP_ACC_C;
        state_d  = ST_ACC_S;
      end
      ST_ACC_S: begin
        cmd_o.op = OP_ACC_S;
        state_d  = ST_DIVPREP;
      end
      ST_DIVPREP: begin
        cmd_o.op = OP_DIVPREP;
        cnt_d    = '0;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == CNTW'(NUMW)) begin
          // quotient ready: emit the point once the output register frees up
          if (stat_i.out_free) begin
            cmd_o.op = OP_POINT;
            state_d  = stat_i.last_point ? ST_IDLE : ST_WGT;
          end
        end else begin
          cmd_o.op = OP_DIVSTEP;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* rtl/qcf_dp.sv */
`timescale 1ns / 1ps
// Datapath of the quadratic curve flattener: path state, part count search,
// Bezier evaluation, serial dividers and the output register.
module qcf_dp #(
  parameter int MAX_PARTS = 63,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_idx_i,
  input  logic [qcf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic [1:0]                          mode_i,
  input  logic signed [qcf_pkg::COORD_W-1:0]  end_x_i,
  input  logic signed [qcf_pkg::COORD_W-1:0]  end_y_i,
  input  logic signed [qcf_pkg::COORD_W-1:0]  ctrl_x_i,
  input  logic signed [qcf_pkg::COORD_W-1:0]  ctrl_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          code_o,
  output logic signed [qcf_pkg::COORD_W-1:0]  vert_x_o,
  output logic signed [qcf_pkg::COORD_W-1:0]  vert_y_o,
  output logic                                last_o,
  input  qcf_pkg::cmd_t                       cmd_i,
  output qcf_pkg::stat_t                      stat_o
);
  import qcf_pkg::*;

  localparam int IW   = $clog2(MAX_PARTS + 1);
  localparam int KW   = $clog2(MAX_PARTS + 2);
  localparam int WW   = 2 * IW;
  localparam int NUMW = num_width(MAX_PARTS);
  localparam int LSH  = 16 + FRAC_BITS;
  localparam int NUDGE = ((1 << FRAC_BITS) + 50) / 100;
  localparam logic [KW-1:0] MAXK = KW'(MAX_PARTS);

  // configuration
  logic                 fill_mode_q;
  logic [DENSITY_W-1:0] density_q;

  // latched item
  mode_e                      mode_q;
  logic signed [COORD_W-1:0]  ex_q, ey_q, cx_q, cy_q;

  // path state
  logic signed [COORD_W-1:0] cur_x_q, cur_y_q, held_x_q, held_y_q, bef_x_q, bef_y_q;
  code_e held_code_q, bef_code_q;
  logic  held_valid_q, bef_valid_q;

  // part count
  logic [34:0] d_q;
  logic [46:0] p1_q;
  logic [58:0] rhs_q;
  logic [KW-1:0]   k_q;
  logic [2*KW-1:0] ksq_q;
  logic [IW-1:0]   parts_q, n_q, i_q;
  logic [WW-1:0]   nsq_q, w_i2_q, w_ir_q, w_r2_q;

  // evaluation and division
  logic signed [NUMW-1:0] accx_q, accy_q;
  logic                   negx_q, negy_q;
  logic [NUMW-1:0]        dvdx_q, dvdy_q;
  logic [WW-1:0]          remx_q, remy_q;

  // output register
  logic                      out_valid_q;
  code_e                     out_code_q;
  logic signed [COORD_W-1:0] out_x_q, out_y_q;
  logic                      out_last_q;

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // ---- combinational helpers ----
  logic signed [34:0] sx35, sy35, ex35, ey35, cx35, cy35, ddx, ddy;
  logic [33:0] magx, magy;
  logic [63:0] lhs;
  logic        search_done;
  logic [IW-1:0] r_val, n_val;
  logic signed [NUMW-1:0] half_n, nsq_s, qx, qy;
  logic [WW:0] trx, try_;
  logic gex, gey;
  logic signed [COORD_W-1:0] ptx, pty;
  logic next_line, nudge, emit_held;
  logic signed [COORD_W:0] nudge_sum;
  logic signed [COORD_W-1:0] flush_x;

  always_comb begin
    sx35 = 35'(cur_x_q);
    sy35 = 35'(cur_y_q);
    ex35 = 35'(ex_q);
    ey35 = 35'(ey_q);
    cx35 = 35'(cx_q);
    cy35 = 35'(cy_q);
    ddx  = ex35 - (cx35 <<< 1) + sx35;
    ddy  = ey35 - (cy35 <<< 1) + sy35;
    magx = ddx[34] ? 34'(-ddx) : 34'(ddx);
    magy = ddy[34] ? 34'(-ddy) : 34'(ddy);
  end

  assign lhs         = 64'(ksq_q) << LSH;
  assign search_done = !((k_q <= MAXK) && (lhs <= 64'(rhs_q)));
  assign n_val       = (parts_q == '0) ? IW'(1) : parts_q;
  assign r_val       = n_q - i_q;

  assign half_n = $signed(NUMW'({1'b0, nsq_q[WW-1:1]}));
  assign nsq_s  = $signed(NUMW'(nsq_q));
  assign qx     = accx_q + half_n;
  assign qy     = accy_q + half_n;

  assign trx  = {remx_q, dvdx_q[NUMW-1]};
  assign try_ = {remy_q, dvdy_q[NUMW-1]};
  assign gex  = (trx >= (WW+1)'(nsq_q));
  assign gey  = (try_ >= (WW+1)'(nsq_q));

  assign ptx = negx_q ? -$signed(dvdx_q[COORD_W-1:0]) : $signed(dvdx_q[COORD_W-1:0]);
  assign pty = negy_q ? -$signed(dvdy_q[COORD_W-1:0]) : $signed(dvdy_q[COORD_W-1:0]);

  // Dotted point: a moveto then a lineto at the same spot, not followed by a lineto.
  assign next_line = (cmd_i.op == OP_POINT) ||
                     ((cmd_i.op == OP_PUSH_IN) && (mode_q == MODE_LINE));
  assign nudge = !fill_mode_q && bef_valid_q && (bef_code_q == CODE_MOVE) &&
                 (held_code_q == CODE_LINE) && !next_line &&
                 (bef_x_q == held_x_q) && (bef_y_q == held_y_q);
  assign nudge_sum = (COORD_W+1)'(held_x_q) + (COORD_W+1)'(NUDGE);
  always_comb begin
    flush_x = held_x_q;
    if (nudge) begin
      flush_x = (nudge_sum > (COORD_W+1)'(32'sh7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                            : nudge_sum[COORD_W-1:0];
    end
  end

  assign emit_held = held_valid_q && ((cmd_i.op == OP_PUSH_IN) ||
                     (cmd_i.op == OP_POINT) || (cmd_i.op == OP_FLUSH));

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_mode_q  <= FILL_MODE_RESET;
      density_q    <= DENSITY_RESET;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      held_code_q  <= CODE_MOVE;
      held_x_q     <= '0;
      held_y_q     <= '0;
      held_valid_q <= 1'b0;
      bef_code_q   <= CODE_MOVE;
      bef_x_q      <= '0;
      bef_y_q      <= '0;
      bef_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FILL_MODE: fill_mode_q <= cfg_wdata_i[0];
          CFG_DENSITY:   density_q   <= cfg_wdata_i[DENSITY_W-1:0];
          default:       ;
        endcase
      end

      if (emit_held) begin
        bef_code_q  <= held_code_q;
        bef_x_q     <= flush_x;
        bef_y_q     <= held_y_q;
        bef_valid_q <= 1'b1;
      end

      case (cmd_i.op)
        OP_PUSH_IN: begin
          held_code_q  <= (mode_q == MODE_LINE) ? CODE_LINE : CODE_MOVE;
          held_x_q     <= ex_q;
          held_y_q     <= ey_q;
          held_valid_q <= 1'b1;
          cur_x_q      <= ex_q;
          cur_y_q      <= ey_q;
        end
        OP_FLUSH: held_valid_q <= 1'b0;
        OP_POINT: begin
          held_code_q  <= CODE_LINE;
          held_x_q     <= ptx;
          held_y_q     <= pty;
          held_valid_q <= 1'b1;
          if (i_q == n_q) begin
            cur_x_q <= ex_q;
            cur_y_q <= ey_q;
          end
        end
        OP_END: begin
          cur_x_q      <= '0;
          cur_y_q      <= '0;
          held_code_q  <= CODE_MOVE;
          held_x_q     <= '0;
          held_y_q     <= '0;
          held_valid_q <= 1'b0;
          bef_code_q   <= CODE_MOVE;
          bef_x_q      <= '0;
          bef_y_q      <= '0;
          bef_valid_q  <= 1'b0;
        end
        default: ;
      endcase

      if (emit_held || (cmd_i.op == OP_END)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (emit_held) begin
      out_code_q <= held_code_q;
      out_x_q    <= flush_x;
      out_y_q    <= held_y_q;
      out_last_q <= (cmd_i.op == OP_PUSH_IN) ||
                    ((cmd_i.op == OP_POINT) && (i_q == n_q));
    end else if (cmd_i.op == OP_END) begin
      out_code_q <= CODE_END;
      out_x_q    <= '0;
      out_y_q    <= '0;
      out_last_q <= 1'b1;
    end

    case (cmd_i.op)
      OP_LOAD: begin
        mode_q <= mode_e'(mode_i);
        ex_q   <= end_x_i;
        ey_q   <= end_y_i;
        cx_q   <= ctrl_x_i;
        cy_q   <= ctrl_y_i;
      end
      OP_DIFF:  d_q  <= 35'(magx) + 35'(magy);
      OP_MUL1:  p1_q <= 47'(d_q * density_q);
      OP_MUL2: begin
        rhs_q   <= 59'(p1_q * density_q);
        k_q     <= KW'(1);
        ksq_q   <= (2*KW)'(1);
        parts_q <= '0;
      end
      OP_SEARCH: begin
        parts_q <= k_q[IW-1:0];
        k_q     <= k_q + 1'b1;
        ksq_q   <= ksq_q + (2*KW)'({k_q, 1'b1});
      end
      OP_SETUP: begin
        n_q   <= n_val;
        nsq_q <= WW'(n_val * n_val);
        i_q   <= '0;
      end
      OP_WGT: begin
        w_i2_q <= WW'(i_q * i_q);
        w_ir_q <= WW'(i_q * r_val);
        w_r2_q <= WW'(r_val * r_val);
        accx_q <= '0;
        accy_q <= '0;
      end
      OP_ACC_E: begin
        accx_q <= accx_q + NUMW'($signed(ex_q) * $signed({1'b0, w_i2_q}));
        accy_q <= accy_q + NUMW'($signed(ey_q) * $signed({1'b0, w_i2_q}));
      end
      OP_ACC_C: begin
        accx_q <= accx_q + NUMW'($signed({cx_q, 1'b0}) * $signed({1'b0, w_ir_q}));
        accy_q <= accy_q + NUMW'($signed({cy_q, 1'b0}) * $signed({1'b0, w_ir_q}));
      end
      OP_ACC_S: begin
        accx_q <= accx_q + NUMW'($signed(cur_x_q) * $signed({1'b0, w_r2_q}));
        accy_q <= accy_q + NUMW'($signed(cur_y_q) * $signed({1'b0, w_r2_q}));
      end
      OP_DIVPREP: begin
        // floor division: a negative numerator divides its magnitude rounded up
        negx_q <= qx[NUMW-1];
        negy_q <= qy[NUMW-1];
        dvdx_q <= qx[NUMW-1] ? NUMW'(nsq_s - qx - 1) : NUMW'(qx);
        dvdy_q <= qy[NUMW-1] ? NUMW'(nsq_s - qy - 1) : NUMW'(qy);
        remx_q <= '0;
        remy_q <= '0;
      end
      OP_DIVSTEP: begin
        remx_q <= gex ? WW'(trx - (WW+1)'(nsq_q)) : WW'(trx);
        remy_q <= gey ? WW'(try_ - (WW+1)'(nsq_q)) : WW'(try_);
        dvdx_q <= {dvdx_q[NUMW-2:0], gex};
        dvdy_q <= {dvdy_q[NUMW-2:0], gey};
      end
      OP_POINT: i_q <= i_q + 1'b1;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign code_o      = out_code_q;
  assign vert_x_o    = out_x_q;
  assign vert_y_o    = out_y_q;
  assign last_o      = out_last_q;

  assign stat_o.mode        = mode_q;
  assign stat_o.held_valid  = held_valid_q;
  assign stat_o.search_done = search_done;
  assign stat_o.last_point  = (i_q == n_q);
  assign stat_o.out_free    = out_free;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DIVSTEP) |=> (remx_q < nsq_q) && (remy_q < nsq_q))
    else $error("divider remainder not below divisor");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_END) |=> !held_valid_q && !bef_valid_q && out_valid_q)
    else $error("end of path left state behind");

  a_point_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_POINT) |=> held_valid_q && (held_code_q == CODE_LINE))
    else $error("spline point not held as lineto");

  a_parts_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SETUP) |=> (n_q >= IW'(1)) && (n_q <= IW'(MAX_PARTS)))
    else $error("part count out of range");

endmodule

/* rtl/quad_curve_flattener.sv */
`timescale 1ns / 1ps
// Top level of the quadratic curve flattener.
//
// Usage: path commands enter on the input channel (in_valid_i / in_stall_o);
// a transaction is taken at a clock edge with valid high and stall low.
// Vertices leave on the output channel (out_valid_o / out_stall_i) with
// last_o marking the final vertex caused by one input command.
// One command is worked at a time; in_stall_o is high from acceptance until
// the command's last step. A new vertex is first held back and is written
// to the output register by a later step. A spline runs a serial part count
// search, then evaluates (parts + 1) points, as the two serial restoring
// dividers (one per axis, one quotient bit a cycle, 47 bits) set the pace.
// End of path writes out the held vertex, if any, and then the end code.
// A stalled receiver holds the output register; the block waits to write the
// next vertex until that transaction completes, and holds its own work.
// Reset clears the path state and loads fill_mode = 1, density = 614.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
// the block is idle.
module quad_curve_flattener #(
  parameter int MAX_PARTS = 63,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_idx_i,
  input  logic [qcf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic signed [qcf_pkg::COORD_W-1:0]  end_x_i,
  input  logic signed [qcf_pkg::COORD_W-1:0]  end_y_i,
  input  logic signed [qcf_pkg::COORD_W-1:0]  ctrl_x_i,
  input  logic signed [qcf_pkg::COORD_W-1:0]  ctrl_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          code_o,
  output logic signed [qcf_pkg::COORD_W-1:0]  vert_x_o,
  output logic signed [qcf_pkg::COORD_W-1:0]  vert_y_o,
  output logic                                last_o
);
  import qcf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence each command: decode, part count, point evaluation, emission.
  qcf_ctrl #(
    .MAX_PARTS(MAX_PARTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // Hold the path state and the held-back vertex; evaluate and divide.
  qcf_dp #(
    .MAX_PARTS(MAX_PARTS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (mode_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .ctrl_x_i    (ctrl_x_i),
    .ctrl_y_i    (ctrl_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_o      (code_o),
    .vert_x_o    (vert_x_o),
    .vert_y_o    (vert_y_o),
    .last_o      (last_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
